### rtl/core/scpd_pkg.sv
// Shared types and constants for the sum-checked packet deframer.
// Used by the frame engine, the top level and the checker; depends on nothing else.
package scpd_pkg;

   localparam int unsigned HeaderBytes = 9;

   localparam logic [7:0] SYNC_FIRST  = 8'hef;
   localparam logic [7:0] SYNC_SECOND = 8'h01;
   localparam logic [7:0] TYPE_ACK    = 8'h07;
   localparam logic [15:0] IDLE_MAX   = 16'hffff;
   localparam logic [15:0] TIMEOUT_RESET = 16'd50;

   // Frame parser phases
   localparam logic [3:0] PH_HUNT0 = 4'd0;
   localparam logic [3:0] PH_HUNT1 = 4'd1;
   localparam logic [3:0] PH_ADDR  = 4'd2;
   localparam logic [3:0] PH_TYPE  = 4'd3;
   localparam logic [3:0] PH_LENH  = 4'd4;
   localparam logic [3:0] PH_LENL  = 4'd5;
   localparam logic [3:0] PH_PAY   = 4'd6;
   localparam logic [3:0] PH_CHKH  = 4'd7;
   localparam logic [3:0] PH_CHKL  = 4'd8;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CHKSUM  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_BADLEN  = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [7:0]  packet_type;
      logic [7:0]  ack_code;
      logic [16:0] frame_length;
   } scpd_result_type;

endpackage

### rtl/core/scpd_engine.sv
// Frame engine: header hunt, length and checksum tracking, idle timeout.
// Depends on scpd_pkg; one request is processed in every cycle that step is high.
module scpd_engine
   import scpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            operation,
   input  logic [7:0]      rx_byte,
   input  logic [15:0]     timeout_ticks,
   output logic            res_valid,
   output scpd_result_type res
);

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  chk_hi_ff, chk_hi_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  ack_ff, ack_in;
   logic [15:0] idle_ff, idle_in;
   logic        reported_ff, reported_in;

   logic [15:0] limit;
   logic [15:0] len_low;
   logic [15:0] sum_add;
   logic [16:0] flen_cur;
   logic [16:0] flen_low;
   logic        sum_ok;

   always_comb begin
      limit    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
      len_low  = len_ff | {8'd0, rx_byte};
      sum_add  = sum_ff + {8'd0, rx_byte};
      flen_cur = {1'b0, len_ff} + 17'(HeaderBytes);
      flen_low = {1'b0, len_low} + 17'(HeaderBytes);
      sum_ok   = ({chk_hi_ff, rx_byte} == sum_ff);

      phase_in    = phase_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      chk_hi_in   = chk_hi_ff;
      type_in     = type_ff;
      ack_in      = ack_ff;
      idle_in     = idle_ff;
      reported_in = reported_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (operation == OP_TICK) begin
         if (idle_ff != IDLE_MAX) begin
            idle_in = idle_ff + 16'd1;
         end
         if (!reported_ff && idle_in >= limit) begin
            reported_in = 1'b1;
            phase_in    = PH_HUNT0;
            count_in    = 16'd0;
            res_valid   = 1'b1;
            res.kind    = KIND_STATUS;
            res.status  = ST_TIMEOUT;
         end
      end else begin
         idle_in     = 16'd0;
         reported_in = 1'b0;
         case (phase_ff)
            PH_HUNT0: begin
               if (rx_byte == SYNC_FIRST) begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_HUNT1: begin
               if (rx_byte == SYNC_SECOND) begin
                  phase_in = PH_ADDR;
                  count_in = 16'd0;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_ADDR: begin
               count_in = count_ff + 16'd1;
               if (count_in >= 16'd4) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               ack_in   = 8'd0;
               sum_in   = {8'd0, rx_byte};
               phase_in = PH_LENH;
            end
            PH_LENH: begin
               len_in   = {rx_byte, 8'd0};
               sum_in   = sum_add;
               phase_in = PH_LENL;
            end
            PH_LENL: begin
               len_in = len_low;
               sum_in = sum_add;
               if (len_low < 16'd2) begin
                  // Too short to hold even the checksum: report and resync.
                  phase_in         = PH_HUNT0;
                  reported_in      = 1'b1;
                  res_valid        = 1'b1;
                  res.kind         = KIND_STATUS;
                  res.status       = ST_BADLEN;
                  res.packet_type  = type_ff;
                  res.frame_length = flen_low;
               end else begin
                  count_in = len_low - 16'd2;
                  phase_in = (len_low == 16'd2) ? PH_CHKH : PH_PAY;
               end
            end
            PH_PAY: begin
               if (count_ff == len_ff - 16'd2) begin
                  ack_in = rx_byte;
               end
               sum_in   = sum_add;
               count_in = count_ff - 16'd1;
               if (count_in == 16'd0) begin
                  phase_in = PH_CHKH;
               end
               res_valid        = 1'b1;
               res.kind         = KIND_DATA;
               res.data_byte    = rx_byte;
               res.packet_type  = type_ff;
               res.frame_length = flen_cur;
            end
            PH_CHKH: begin
               chk_hi_in = rx_byte;
               phase_in  = PH_CHKL;
            end
            PH_CHKL: begin
               phase_in         = PH_HUNT0;
               reported_in      = 1'b1;
               res_valid        = 1'b1;
               res.kind         = KIND_STATUS;
               res.status       = sum_ok ? ST_OK : ST_CHKSUM;
               res.packet_type  = type_ff;
               res.frame_length = flen_cur;
               if (sum_ok && type_ff == TYPE_ACK && len_ff > 16'd2) begin
                  res.ack_code = ack_ff;
               end
            end
            default: begin
               phase_in = PH_HUNT0;
            end
         endcase
      end

      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT0;
         count_ff    <= 16'd0;
         len_ff      <= 16'd0;
         sum_ff      <= 16'd0;
         chk_hi_ff   <= 8'd0;
         type_ff     <= 8'd0;
         ack_ff      <= 8'd0;
         idle_ff     <= 16'd0;
         reported_ff <= 1'b1;
      end else if (step) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         len_ff      <= len_in;
         sum_ff      <= sum_in;
         chk_hi_ff   <= chk_hi_in;
         type_ff     <= type_in;
         ack_ff      <= ack_in;
         idle_ff     <= idle_in;
         reported_ff <= reported_in;
      end
   end

endmodule

### rtl/core/sum_checked_packet_deframer_top.sv
// Top level of the sum-checked packet deframer: request register, frame engine,
// timeout register and a two-entry response buffer. Depends on scpd_pkg, scpd_engine.

// One request (a received byte or a millisecond tick) is taken every cycle
// that req_stall is low. An accepted request sits in the request register
// until the frame engine, whose state update is registered, works on it; the
// engine's response is combinational and is registered into the output
// register or the skid entry, from which it drives the rsp_ ports.
// Payload bytes are forwarded as they arrive and each frame ends in one status
// response (ok, checksum error, timeout or bad length). The response side has
// an output register and a skid entry, so requests keep flowing while one
// response waits on rsp_stall; req_stall rises only when both are occupied.
// timeout_ticks should be written only while the block is idle; zero behaves
// as one.
module sum_checked_packet_deframer_top
   import scpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_packet_type,
   output logic [7:0]  rsp_ack_code,
   output logic [16:0] rsp_frame_length,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic            in_valid_ff, in_valid_in;
   logic            in_op_ff;
   logic [7:0]      in_byte_ff;
   logic [15:0]     timeout_ff;
   logic            out_valid_ff, out_valid_in;
   scpd_result_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   scpd_result_type skid_ff, skid_in;

   logic            accept;
   logic            step;
   logic            res_valid;
   scpd_result_type res;

   assign req_stall = in_valid_ff & skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   // The engine only runs when the skid entry is free to catch its response.
   assign step      = in_valid_ff & ~skid_valid_ff;

   scpd_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .operation     (in_op_ff),
      .rx_byte       (in_byte_ff),
      .timeout_ticks (timeout_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_rx_byte;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_status       = out_ff.status;
   assign rsp_packet_type  = out_ff.packet_type;
   assign rsp_ack_code     = out_ff.ack_code;
   assign rsp_frame_length = out_ff.frame_length;

endmodule

### rtl/core/scpd_checker.sv
// Port-level checks for the sum-checked packet deframer, bound to the top level.
// Depends on scpd_pkg for the response codes.
module scpd_checker
   import scpd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_packet_type,
   input logic [7:0]  rsp_ack_code,
   input logic [16:0] rsp_frame_length
);

   // Nothing can be in flight straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Payload responses carry no status and no acknowledge code.
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DATA) |-> (rsp_status == ST_OK && rsp_ack_code == 8'd0))
      else $error("payload response with status or ack code");

   // A timeout carries no frame information.
   a_timeout_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_STATUS && rsp_status == ST_TIMEOUT)
      |-> (rsp_packet_type == 8'd0 && rsp_frame_length == 17'd0 && rsp_ack_code == 8'd0))
      else $error("timeout response with frame fields");

   // Every other response describes a frame of at least the header size.
   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_kind == KIND_STATUS && rsp_status == ST_TIMEOUT))
      |-> (rsp_frame_length >= 17'(HeaderBytes)))
      else $error("frame length below header size");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data_byte) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind sum_checked_packet_deframer_top scpd_checker u_scpd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_status       (rsp_status),
   .rsp_packet_type  (rsp_packet_type),
   .rsp_ack_code     (rsp_ack_code),
   .rsp_frame_length (rsp_frame_length)
);
